// ----- src/e2q_pkg.sv -----
// Package for the Euler angle to quaternion block: widths, series tables and
// the sine/cosine word passed between the half-angle units and the top level.
// Depends on nothing.
package e2q_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int QUAT_BITS_DEF  = 16;

  localparam int FRAC  = 30;
  localparam int MAG_W = 31;
  localparam logic [MAG_W-1:0] ONE_Q  = MAG_W'(1) << FRAC;
  localparam logic [31:0]      PI_Q30 = 32'd3373259426;

  localparam int HORNER_STEPS = 6;
  localparam int RCP_SHIFT    = 40;
  localparam logic [63:0] RCP_ONE = 64'd1 << RCP_SHIFT;

  // Rounded-up reciprocals of the series denominators, scaled by 2^40.
  localparam logic [RCP_SHIFT-1:0] SIN_RCP [HORNER_STEPS] = '{
    RCP_SHIFT'((RCP_ONE + 64'd155) / 64'd156),
    RCP_SHIFT'((RCP_ONE + 64'd109) / 64'd110),
    RCP_SHIFT'((RCP_ONE + 64'd71) / 64'd72),
    RCP_SHIFT'((RCP_ONE + 64'd41) / 64'd42),
    RCP_SHIFT'((RCP_ONE + 64'd19) / 64'd20),
    RCP_SHIFT'((RCP_ONE + 64'd5) / 64'd6)
  };
  localparam logic [RCP_SHIFT-1:0] COS_RCP [HORNER_STEPS] = '{
    RCP_SHIFT'((RCP_ONE + 64'd181) / 64'd182),
    RCP_SHIFT'((RCP_ONE + 64'd131) / 64'd132),
    RCP_SHIFT'((RCP_ONE + 64'd89) / 64'd90),
    RCP_SHIFT'((RCP_ONE + 64'd55) / 64'd56),
    RCP_SHIFT'((RCP_ONE + 64'd29) / 64'd30),
    RCP_SHIFT'((RCP_ONE + 64'd11) / 64'd12)
  };

  localparam int TRIG_STAGES = 24;
  localparam int MIX_STAGES  = 7;

  // Roll-pitch pairs: 0 sr*cp, 1 cr*sp, 2 cr*cp, 3 sr*sp.
  localparam logic [1:0] TERM_PAIR [8] = '{2'd0, 2'd1, 2'd1, 2'd0, 2'd2, 2'd3, 2'd2, 2'd3};
  localparam logic TERM_YAW_SIN [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
  localparam logic COMP_SUB [4] = '{1'b1, 1'b0, 1'b1, 1'b0};

  typedef struct packed {
    logic             s_neg;
    logic [MAG_W-1:0] s_mag;
    logic [MAG_W-1:0] c;
  } trig_t;

endpackage

// ----- src/e2q_in_if.sv -----
// Input channel of the Euler angle to quaternion block: one angle triple per word.
// Depends on e2q_pkg for the default angle width.
interface e2q_in_if #(
  parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] roll_angle;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] yaw_angle;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

// ----- src/e2q_out_if.sv -----
// Result channel of the Euler angle to quaternion block: one quaternion per word.
// Depends on e2q_pkg for the default component width.
interface e2q_out_if #(
  parameter int QUAT_BITS = e2q_pkg::QUAT_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [QUAT_BITS-1:0] quat_x;
  logic signed [QUAT_BITS-1:0] quat_y;
  logic signed [QUAT_BITS-1:0] quat_z;
  logic signed [QUAT_BITS-1:0] quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// ----- src/e2q_half_trig.sv -----
// Pipelined sine and cosine of half a binary angle, sign-magnitude Q1.30, 24 register stages.
// Depends on e2q_pkg for the series reciprocals and the trig_t result word.
module e2q_half_trig #(
  parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output e2q_pkg::trig_t               trig
);

  localparam int MW = e2q_pkg::MAG_W;
  localparam int FR = e2q_pkg::FRAC;
  localparam int NS = e2q_pkg::HORNER_STEPS;
  localparam int PW = ANGLE_BITS + 32;
  localparam logic [PW-1:0] H_RND = PW'(1) << (ANGLE_BITS - 1);

  typedef struct packed {
    logic          neg;
    logic [MW-1:0] h;
    logic [31:0]   h2;
  } carry_t;

  logic [ANGLE_BITS-1:0] ang_u;
  logic [ANGLE_BITS-1:0] mag1_nxt;
  logic [ANGLE_BITS-1:0] mag1_r;
  logic                  neg1_r;
  logic                  neg2_r;
  logic                  neg3_r;
  logic [PW-1:0]         hp2_r;
  logic [PW-1:0]         hr3_sum;
  logic [MW-1:0]         h3_r;
  logic [2*MW-1:0]       hh4;
  carry_t                c4_r;

  carry_t        ka_r [NS];
  carry_t        kb_r [NS];
  carry_t        kc_r [NS];
  logic [31:0]   sa_r [NS];
  logic [63:0]   sblo_r [NS];
  logic [39:0]   sbhi_r [NS];
  logic [MW-1:0] st_r [NS];
  logic [31:0]   ca_r [NS];
  logic [63:0]   cblo_r [NS];
  logic [39:0]   cbhi_r [NS];
  logic [MW-1:0] ct_r [NS];

  logic [2*MW-1:0] sf1;
  logic [2*MW:0]   cf1;
  logic            f1_neg_r;
  logic [31:0]     f1_sp_r;
  logic [31:0]     f1_cp_r;
  logic [MW-1:0]   d_f2;
  e2q_pkg::trig_t  trig_nxt;
  e2q_pkg::trig_t  trig_r;

  assign ang_u    = angle;
  assign mag1_nxt = ang_u[ANGLE_BITS-1] ? (~ang_u + 1'b1) : ang_u;
  assign hr3_sum  = hp2_r + H_RND;
  assign hh4      = {{MW{1'b0}}, h3_r} * {{MW{1'b0}}, h3_r};

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r    <= mag1_nxt;
      neg1_r    <= ang_u[ANGLE_BITS-1];
      hp2_r     <= mag1_r * e2q_pkg::PI_Q30;
      neg2_r    <= neg1_r;
      h3_r      <= hr3_sum[ANGLE_BITS +: MW];
      neg3_r    <= neg2_r;
      c4_r.neg  <= neg3_r;
      c4_r.h    <= h3_r;
      c4_r.h2   <= hh4[FR +: 32];
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    carry_t        kin;
    logic [MW-1:0] sin_t;
    logic [MW-1:0] cos_t;
    logic [62:0]   sprod;
    logic [62:0]   cprod;
    logic [71:0]   sqsum;
    logic [71:0]   cqsum;

    if (k == 0) begin : g_first
      assign kin   = c4_r;
      assign sin_t = e2q_pkg::ONE_Q;
      assign cos_t = e2q_pkg::ONE_Q;
    end else begin : g_next
      assign kin   = kc_r[k-1];
      assign sin_t = st_r[k-1];
      assign cos_t = ct_r[k-1];
    end

    assign sprod = {31'b0, kin.h2} * {32'b0, sin_t};
    assign cprod = {31'b0, kin.h2} * {32'b0, cos_t};
    assign sqsum = {sbhi_r[k], 32'b0} + {8'b0, sblo_r[k]};
    assign cqsum = {cbhi_r[k], 32'b0} + {8'b0, cblo_r[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        ka_r[k]   <= kin;
        sa_r[k]   <= sprod[FR +: 32];
        ca_r[k]   <= cprod[FR +: 32];
        kb_r[k]   <= ka_r[k];
        sblo_r[k] <= {32'b0, sa_r[k]} * {32'b0, e2q_pkg::SIN_RCP[k][31:0]};
        sbhi_r[k] <= {8'b0, sa_r[k]} * {32'b0, e2q_pkg::SIN_RCP[k][39:32]};
        cblo_r[k] <= {32'b0, ca_r[k]} * {32'b0, e2q_pkg::COS_RCP[k][31:0]};
        cbhi_r[k] <= {8'b0, ca_r[k]} * {32'b0, e2q_pkg::COS_RCP[k][39:32]};
        kc_r[k]   <= kb_r[k];
        st_r[k]   <= e2q_pkg::ONE_Q - sqsum[e2q_pkg::RCP_SHIFT +: MW];
        ct_r[k]   <= e2q_pkg::ONE_Q - cqsum[e2q_pkg::RCP_SHIFT +: MW];
      end
    end
  end

  assign sf1 = {{MW{1'b0}}, kc_r[NS-1].h} * {{MW{1'b0}}, st_r[NS-1]};
  assign cf1 = {31'b0, kc_r[NS-1].h2} * {32'b0, ct_r[NS-1]};

  // The last cosine term divides by two; both series are clamped to [0, 1.0].
  always_comb begin
    d_f2           = f1_cp_r[31:1];
    trig_nxt.s_neg = f1_neg_r;
    trig_nxt.s_mag = (f1_sp_r > {1'b0, e2q_pkg::ONE_Q}) ? e2q_pkg::ONE_Q : f1_sp_r[MW-1:0];
    trig_nxt.c     = (d_f2 >= e2q_pkg::ONE_Q) ? '0 : (e2q_pkg::ONE_Q - d_f2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_neg_r <= kc_r[NS-1].neg;
      f1_sp_r  <= sf1[FR +: 32];
      f1_cp_r  <= cf1[FR +: 32];
      trig_r   <= trig_nxt;
    end
  end

  assign trig = trig_r;

endmodule

// ----- src/euler_to_quaternion.sv -----
// Roll, pitch and yaw binary angles in, unit quaternion x, y, z, w out.
//
// Usage:
//   in_chan carries one word per angle triple; full scale of each angle is
//   plus or minus pi. out_chan carries one quaternion word per input word, in
//   the same order, each component in signed Q1.(QUAT_BITS-1), rounded and
//   saturated so that 1.0 reads as the largest positive code.
//   A word is moved on a rising edge of clk with valid and ready both high.
//   Throughput is one word per cycle while in_chan.ready is high. The
//   accepting edge loads the first of 24 stages that form the half-angle
//   sine and cosine (six series steps of multiply, reciprocal and subtract),
//   7 stages form the products, sums and rounding, and one output register
//   follows.
//   While the receiver stalls, a second output register takes one more word;
//   in_chan.ready falls only while that register is full, and the pipeline
//   then holds every stage. in_chan.ready depends on registers alone.
//   A synchronous reset on rst_n low empties the pipeline and both output
//   registers; no state survives between words.
// Depends on e2q_pkg, e2q_in_if, e2q_out_if and e2q_half_trig.
module euler_to_quaternion #(
  parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF,
  parameter int QUAT_BITS  = e2q_pkg::QUAT_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  e2q_in_if.sink    in_chan,
  e2q_out_if.source out_chan
);

  localparam int MW    = e2q_pkg::MAG_W;
  localparam int FR    = e2q_pkg::FRAC;
  localparam int NPIPE = e2q_pkg::TRIG_STAGES + e2q_pkg::MIX_STAGES;
  localparam int SH    = 31 - QUAT_BITS;
  localparam logic [2*MW-1:0] RND_Q30 = (2*MW)'(1) << (FR - 1);
  localparam logic [31:0]     RND_OUT = 32'(1) << (SH - 1);
  localparam logic [QUAT_BITS-1:0] Q_MIN   = {1'b1, {(QUAT_BITS-1){1'b0}}};
  localparam logic [QUAT_BITS-1:0] Q_MAX   = {1'b0, {(QUAT_BITS-1){1'b1}}};
  localparam logic [QUAT_BITS:0]   LIM_NEG = {2'b01, {(QUAT_BITS-1){1'b0}}};
  localparam logic [QUAT_BITS:0]   LIM_POS = {2'b00, {(QUAT_BITS-1){1'b1}}};

  e2q_pkg::trig_t rt;
  e2q_pkg::trig_t pt;
  e2q_pkg::trig_t yt;

  logic             adv;
  logic [NPIPE-1:0] v_r;

  logic [2*MW-1:0] pp1_r [4];
  logic            pn1_r [4];
  e2q_pkg::trig_t  yt1_r;
  logic [2*MW-1:0] rs2 [4];
  logic [MW-1:0]   pm2_r [4];
  logic            pn2_r [4];
  e2q_pkg::trig_t  yt2_r;
  logic [2*MW-1:0] tp3_nxt [8];
  logic            tn3_nxt [8];
  logic [2*MW-1:0] tp3_r [8];
  logic            tn3_r [8];
  logic [2*MW-1:0] rs4 [8];
  logic [MW-1:0]   tm4_r [8];
  logic            tn4_r [8];
  logic [31:0]     sum5 [4];
  logic [31:0]     dab5 [4];
  logic [31:0]     dba5 [4];
  logic            sbp5 [4];
  logic [31:0]     cm5_nxt [4];
  logic            cn5_nxt [4];
  logic [31:0]     cm5_r [4];
  logic            cn5_r [4];
  logic [31:0]     rs6 [4];
  logic [QUAT_BITS:0]   mr6_r [4];
  logic                 cn6_r [4];
  logic [QUAT_BITS-1:0] q7_nxt [4];
  logic [QUAT_BITS-1:0] q7_r [4];

  logic                 out_v_r;
  logic                 out_v_nxt;
  logic                 skid_v_r;
  logic                 skid_v_nxt;
  logic                 held;
  logic                 out_load_pipe;
  logic                 out_load_skid;
  logic                 skid_load;
  logic [QUAT_BITS-1:0] out_d_r [4];
  logic [QUAT_BITS-1:0] skid_d_r [4];

  e2q_half_trig #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk   (clk),
    .en    (adv),
    .angle (in_chan.roll_angle),
    .trig  (rt)
  );

  e2q_half_trig #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk   (clk),
    .en    (adv),
    .angle (in_chan.pitch_angle),
    .trig  (pt)
  );

  e2q_half_trig #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk   (clk),
    .en    (adv),
    .angle (in_chan.yaw_angle),
    .trig  (yt)
  );

  assign adv = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NPIPE-2:0], in_chan.valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rs2[i] = pp1_r[i] + RND_Q30;
    end
    for (int j = 0; j < 8; j++) begin
      tp3_nxt[j] = {{MW{1'b0}}, pm2_r[e2q_pkg::TERM_PAIR[j]]} *
                   {{MW{1'b0}}, e2q_pkg::TERM_YAW_SIN[j] ? yt2_r.s_mag : yt2_r.c};
      tn3_nxt[j] = pn2_r[e2q_pkg::TERM_PAIR[j]] ^ (e2q_pkg::TERM_YAW_SIN[j] & yt2_r.s_neg);
      rs4[j]     = tp3_r[j] + RND_Q30;
    end
    for (int i = 0; i < 4; i++) begin
      sbp5[i] = tn4_r[2*i+1] ^ e2q_pkg::COMP_SUB[i];
      sum5[i] = {1'b0, tm4_r[2*i]} + {1'b0, tm4_r[2*i+1]};
      dab5[i] = {1'b0, tm4_r[2*i]} - {1'b0, tm4_r[2*i+1]};
      dba5[i] = {1'b0, tm4_r[2*i+1]} - {1'b0, tm4_r[2*i]};
      if (tn4_r[2*i] == sbp5[i]) begin
        cm5_nxt[i] = sum5[i];
        cn5_nxt[i] = tn4_r[2*i];
      end else if (tm4_r[2*i] >= tm4_r[2*i+1]) begin
        cm5_nxt[i] = dab5[i];
        cn5_nxt[i] = tn4_r[2*i];
      end else begin
        cm5_nxt[i] = dba5[i];
        cn5_nxt[i] = sbp5[i];
      end
      rs6[i] = cm5_r[i] + RND_OUT;
      if (cn6_r[i]) begin
        q7_nxt[i] = (mr6_r[i] > LIM_NEG) ? Q_MIN : (~mr6_r[i][QUAT_BITS-1:0] + 1'b1);
      end else begin
        q7_nxt[i] = (mr6_r[i] > LIM_POS) ? Q_MAX : mr6_r[i][QUAT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pp1_r[0] <= {{MW{1'b0}}, rt.s_mag} * {{MW{1'b0}}, pt.c};
      pn1_r[0] <= rt.s_neg;
      pp1_r[1] <= {{MW{1'b0}}, rt.c} * {{MW{1'b0}}, pt.s_mag};
      pn1_r[1] <= pt.s_neg;
      pp1_r[2] <= {{MW{1'b0}}, rt.c} * {{MW{1'b0}}, pt.c};
      pn1_r[2] <= 1'b0;
      pp1_r[3] <= {{MW{1'b0}}, rt.s_mag} * {{MW{1'b0}}, pt.s_mag};
      pn1_r[3] <= rt.s_neg ^ pt.s_neg;
      yt1_r    <= yt;
      yt2_r    <= yt1_r;
      for (int i = 0; i < 4; i++) begin
        pm2_r[i] <= rs2[i][FR +: MW];
        pn2_r[i] <= pn1_r[i];
        cm5_r[i] <= cm5_nxt[i];
        cn5_r[i] <= cn5_nxt[i];
        mr6_r[i] <= rs6[i][31:SH];
        cn6_r[i] <= cn5_r[i];
        q7_r[i]  <= q7_nxt[i];
      end
      for (int j = 0; j < 8; j++) begin
        tp3_r[j] <= tp3_nxt[j];
        tn3_r[j] <= tn3_nxt[j];
        tm4_r[j] <= rs4[j][FR +: MW];
        tn4_r[j] <= tn3_r[j];
      end
    end
  end

  // Output register plus one skid register; the skid fills only under a stall.
  always_comb begin
    held          = out_v_r && !out_chan.ready;
    out_v_nxt     = out_v_r;
    skid_v_nxt    = skid_v_r;
    out_load_pipe = 1'b0;
    out_load_skid = 1'b0;
    skid_load     = 1'b0;
    if (held) begin
      if (adv && v_r[NPIPE-1]) begin
        skid_v_nxt = 1'b1;
        skid_load  = 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_nxt     = 1'b1;
      skid_v_nxt    = 1'b0;
      out_load_skid = 1'b1;
    end else begin
      out_v_nxt     = v_r[NPIPE-1];
      out_load_pipe = v_r[NPIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_skid) begin
      out_d_r <= skid_d_r;
    end else if (out_load_pipe) begin
      out_d_r <= q7_r;
    end
    if (skid_load) begin
      skid_d_r <= q7_r;
    end
  end

  assign in_chan.ready   = adv;
  assign out_chan.valid  = out_v_r;
  assign out_chan.quat_x = out_d_r[0];
  assign out_chan.quat_y = out_d_r[1];
  assign out_chan.quat_z = out_d_r[2];
  assign out_chan.quat_w = out_d_r[3];

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("Skid register holds a word while the output register is empty.");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_chan.ready))
    else $error("Skid register filled without a stalled output word.");

  a_skid_drain_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(skid_v_r) |-> out_v_r)
    else $error("Skid word left without reaching the output register.");

  a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("Pipeline valid bits moved while the pipeline was held.");

endmodule
